// ===== src/pcm_mixer_volume_fade_in_assert.svh =====
// ----------------------------------------------------------------------------
// PCM mixer assertion macros
// Concurrent assertion wrappers that compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PCM_MIXER_VOLUME_FADE_IN_ASSERT_SVH
`define PCM_MIXER_VOLUME_FADE_IN_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define PMV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcm mixer assertion failed");
// Next-cycle implication, disabled while reset is high.
`define PMV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcm mixer assertion failed");
`else
`define PMV_ASSERT_NOW(label, clk, rst, ante, cons)
`define PMV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/pcmvf_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM mixer package
// Widths, limits and default sizes shared by the mixer and its divider.
// ----------------------------------------------------------------------------
package pcmvf_pkg;

  // Four playback slots plus the stream source.
  localparam int NUM_SLOTS = 4;
  localparam int NUM_SRC   = NUM_SLOTS + 1;
  localparam int SRC_W     = $clog2(NUM_SRC);
  localparam int CNT_W     = $clog2(NUM_SRC + 1);

  localparam int SMP_W      = 16;
  localparam int GAIN_W     = 17;
  localparam int GAIN_SHIFT = 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd65536;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  // Sum of all scaled sources, with a sign bit.
  localparam int SUM_W = SMP_W + $clog2(NUM_SRC) + 1;

  localparam int FADE_LENGTH_DEF = 32;

  // Divider sizes: the sum magnitude divided by the source count.
  localparam int DIV_W_DEF = SUM_W;
  localparam int DVS_W_DEF = CNT_W;

endpackage

// ===== src/pcm_mixer_volume_fade_in.sv =====
// ----------------------------------------------------------------------------
// PCM mixer with volume and fade-in
// Scales each valid source by a Q16 gain, averages the valid sources and
// applies a linear fade-in on the first sounding frames after silence.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  -------------------------------
//  in        input      in_valid / in_ready  slot0..3_sample, slot_valid_mask,
//                                            stream_sample, stream_valid
//  out       output     out_valid/out_ready  mixed_sample, silent
//  cfg       input      cfg_wr_en            cfg_wr_data (volume gain)
//
// A request is accepted when in_valid and in_ready are high at a clock edge.
// Each source of a frame passes through the one shared 16x18 multiplier and
// then the accumulate, and the average takes one pass of the bit-serial
// divider. During a fade the average is multiplied by the fade step and
// divided by the fade length through a constant reciprocal. A silent frame
// skips the divider. A new request is taken only after the previous result
// has gone into the output register. Reset is synchronous and restores unity
// gain and the no-fade state. The finished result waits in the output
// register while the input side takes the next request, and the sequencer
// holds only if that register is still full when the following result is
// ready.
//
// ----------------------------------------------------------------------------
`include "pcm_mixer_volume_fade_in_assert.svh"

module pcm_mixer_volume_fade_in #(
  parameter int FADE_LENGTH = pcmvf_pkg::FADE_LENGTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pcmvf_pkg::SMP_W-1:0]   slot0_sample,
  input  logic signed [pcmvf_pkg::SMP_W-1:0]   slot1_sample,
  input  logic signed [pcmvf_pkg::SMP_W-1:0]   slot2_sample,
  input  logic signed [pcmvf_pkg::SMP_W-1:0]   slot3_sample,
  input  logic [pcmvf_pkg::NUM_SLOTS-1:0]      slot_valid_mask,
  input  logic signed [pcmvf_pkg::SMP_W-1:0]   stream_sample,
  input  logic                                 stream_valid,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pcmvf_pkg::SMP_W-1:0]   mixed_sample,
  output logic                                 silent,
  input  logic                                 cfg_wr_en,
  input  logic [pcmvf_pkg::GAIN_W-1:0]         cfg_wr_data
);

  localparam int SMP_W  = pcmvf_pkg::SMP_W;
  localparam int SUM_W  = pcmvf_pkg::SUM_W;
  localparam int CNT_W  = pcmvf_pkg::CNT_W;
  localparam int SRC_W  = pcmvf_pkg::SRC_W;
  localparam int NUM_SRC = pcmvf_pkg::NUM_SRC;
  localparam int FL_W   = $clog2(FADE_LENGTH + 1);
  localparam int MUL_B_W = pcmvf_pkg::GAIN_W + 1;
  localparam int PROD_W = SMP_W + MUL_B_W;
  localparam int SH_W   = PROD_W - pcmvf_pkg::GAIN_SHIFT;
  localparam int DIV_W  = SUM_W;
  localparam int DVS_W  = CNT_W;

  // The fade product magnitude is below 2^(SMP_W - 1 + FL_W). With a
  // reciprocal rounded up at RCP_K fraction bits the error stays under one
  // part in the fade length for every such product, so the floor is exact.
  localparam int FN_W   = SMP_W - 1 + FL_W;
  localparam int RCP_K  = FN_W + FL_W;
  localparam int RCP_W  = FN_W + 2;
  localparam int FP_W   = FN_W + RCP_W;
  localparam int FQ_W   = FP_W - RCP_K;
  localparam logic [RCP_W-1:0] FADE_RCP =
    RCP_W'(((64'd1 << RCP_K) + 64'(FADE_LENGTH) - 64'd1) / 64'(FADE_LENGTH));

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL       = 4'd1;
  localparam logic [3:0] S_ACC       = 4'd2;
  localparam logic [3:0] S_AVG       = 4'd3;
  localparam logic [3:0] S_AVG_WAIT  = 4'd4;
  localparam logic [3:0] S_FMUL      = 4'd5;
  localparam logic [3:0] S_FDIV      = 4'd6;
  localparam logic [3:0] S_FDIV_WAIT = 4'd7;
  localparam logic [3:0] S_FINISH    = 4'd8;

  logic [3:0]                     state;
  logic signed [SMP_W-1:0]        smp [NUM_SRC];
  logic [NUM_SRC-1:0]             vld;
  logic [SRC_W-1:0]               idx;
  logic signed [SUM_W-1:0]        sum;
  logic [CNT_W-1:0]               cnt;
  logic signed [PROD_W-1:0]       prod;
  logic signed [SMP_W-1:0]        mixed;
  logic signed [SMP_W-1:0]        res;
  logic                           res_silent;
  logic [pcmvf_pkg::GAIN_W-1:0]   gain;
  logic                           was_sounding;
  logic [FL_W-1:0]                fade_remaining;
  logic [FP_W-1:0]                fade_prod;

  logic signed [SMP_W-1:0]        mul_a;
  logic signed [MUL_B_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]       mul_p;
  logic [FL_W-1:0]                step;
  logic signed [SH_W-1:0]         shifted;
  logic signed [SMP_W-1:0]        scaled;
  logic                           sum_neg;
  logic                           prod_neg;
  logic [SUM_W-1:0]               sum_mag;
  logic [PROD_W-1:0]              prod_mag;
  logic [FN_W-1:0]                fade_num;
  logic [FQ_W-1:0]                fade_quo;
  logic [SMP_W-1:0]               fade_fix;
  logic                           div_start;
  logic [DIV_W-1:0]               div_dividend;
  logic [DVS_W-1:0]               div_divisor;
  logic                           div_done;
  logic [DIV_W-1:0]               div_quo;
  logic [DIV_W-1:0]               quo_fix;
  logic [FL_W-1:0]                fade_start;
  logic                           out_load;

  assign in_ready = (state == S_IDLE);

  // Fade frame number, 1 on the first frame of a fade.
  assign step = FL_W'(FADE_LENGTH) - fade_remaining + FL_W'(1);

  // The shared multiplier scales sources by the gain, and later scales the
  // average by the fade step.
  always_comb begin
    if (state == S_FMUL) begin
      mul_a = mixed;
      mul_b = $signed(MUL_B_W'(step));
    end else begin
      mul_a = smp[idx];
      mul_b = $signed({1'b0, gain});
    end
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Arithmetic shift by 16 is a floor divide by 65536; then saturate.
  assign shifted = prod[PROD_W-1:pcmvf_pkg::GAIN_SHIFT];
  always_comb begin
    if (shifted > SH_W'(pcmvf_pkg::SMP_MAX)) begin
      scaled = pcmvf_pkg::SMP_MAX;
    end else if (shifted < SH_W'(pcmvf_pkg::SMP_MIN)) begin
      scaled = pcmvf_pkg::SMP_MIN;
    end else begin
      scaled = shifted[SMP_W-1:0];
    end
  end

  // Both divisions work on magnitudes and put the sign back on the quotient,
  // so that they truncate toward zero.
  assign sum_neg  = sum[SUM_W-1];
  assign prod_neg = prod[PROD_W-1];
  assign sum_mag  = sum_neg ? SUM_W'(-sum) : SUM_W'(sum);
  assign prod_mag = prod_neg ? PROD_W'(-prod) : PROD_W'(prod);

  // The average goes through the divider, since the source count varies.
  assign div_start    = (state == S_AVG) && (cnt != '0);
  assign div_dividend = sum_mag;
  assign div_divisor  = cnt;

  assign quo_fix = sum_neg ? DIV_W'(-div_quo) : div_quo;

  // The fade length is fixed, so its division is a reciprocal multiply.
  assign fade_num = prod_mag[FN_W-1:0];
  assign fade_quo = fade_prod[FP_W-1:RCP_K];
  assign fade_fix = prod_neg ? SMP_W'(-fade_quo) : SMP_W'(fade_quo);

  // A fresh fade starts on the first sounding frame after silence.
  assign fade_start = was_sounding ? fade_remaining : FL_W'(FADE_LENGTH);

  pcmvf_divider #(
    .DIV_W (DIV_W),
    .DVS_W (DVS_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer and frame-to-frame fade state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      gain           <= pcmvf_pkg::GAIN_RESET;
      was_sounding   <= 1'b0;
      fade_remaining <= '0;
    end else begin
      if (cfg_wr_en) begin
        gain <= cfg_wr_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (idx == SRC_W'(NUM_SRC - 1)) begin
            state <= S_AVG;
          end else begin
            state <= S_MUL;
          end
        end
        S_AVG: begin
          if (cnt == '0) begin
            was_sounding   <= 1'b0;
            fade_remaining <= '0;
            state          <= S_FINISH;
          end else begin
            state <= S_AVG_WAIT;
          end
        end
        S_AVG_WAIT: begin
          if (div_done) begin
            was_sounding   <= 1'b1;
            fade_remaining <= fade_start;
            if (fade_start != '0) begin
              state <= S_FMUL;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_FMUL: begin
          fade_remaining <= fade_remaining - FL_W'(1);
          state          <= S_FDIV;
        end
        S_FDIV: begin
          state <= S_FDIV_WAIT;
        end
        S_FDIV_WAIT: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          smp[0] <= slot0_sample;
          smp[1] <= slot1_sample;
          smp[2] <= slot2_sample;
          smp[3] <= slot3_sample;
          smp[4] <= stream_sample;
          vld    <= {stream_valid, slot_valid_mask};
          idx    <= '0;
          sum    <= '0;
          cnt    <= '0;
        end
      end
      S_MUL: begin
        prod <= mul_p;
      end
      S_ACC: begin
        if (vld[idx]) begin
          sum <= sum + SUM_W'(scaled);
          cnt <= cnt + CNT_W'(1);
        end
        if (idx != SRC_W'(NUM_SRC - 1)) begin
          idx <= idx + SRC_W'(1);
        end
      end
      S_AVG: begin
        if (cnt == '0) begin
          res        <= '0;
          res_silent <= 1'b1;
        end else begin
          res_silent <= 1'b0;
        end
      end
      S_AVG_WAIT: begin
        if (div_done) begin
          mixed <= quo_fix[SMP_W-1:0];
          res   <= quo_fix[SMP_W-1:0];
        end
      end
      S_FMUL: begin
        prod <= mul_p;
      end
      S_FDIV: begin
        fade_prod <= FP_W'(fade_num) * FP_W'(FADE_RCP);
      end
      S_FDIV_WAIT: begin
        res <= fade_fix;
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: loads when empty or when its result is being taken.
  assign out_load = (state == S_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mixed_sample <= res;
      silent       <= res_silent;
    end
  end

  // A silent result always carries a zero sample.
  `PMV_ASSERT_NOW(a_silent_zero, clk, rst, out_valid && silent, mixed_sample == '0)
  // The fade counter never runs past its length.
  `PMV_ASSERT_NOW(a_fade_range, clk, rst, 1'b1, fade_remaining <= FL_W'(FADE_LENGTH))
  // A fade in progress implies the previous frame was sounding.
  `PMV_ASSERT_NOW(a_fade_sounding, clk, rst, fade_remaining != '0, was_sounding)
  // After a request is taken the sequencer is busy and the divider shows no done.
  `PMV_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready && !div_done)

endmodule

// ===== src/pcmvf_divider.sv =====
// ----------------------------------------------------------------------------
// PCM mixer divider
// Unsigned restoring divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module pcmvf_divider #(
  parameter int DIV_W = pcmvf_pkg::DIV_W_DEF,
  parameter int DVS_W = pcmvf_pkg::DVS_W_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  quo;
  logic [DVS_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DVS_W:0]    trial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      if (fits) begin
        rem <= DVS_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DVS_W-1:0];
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PCM mixer with volume and fade-in: testbench
// Sends audio frames through the valid/ready input channel and checks each
// mixed result against a local prediction of gain scaling, averaging and
// fade-in. The volume gain is changed between phases, including its extremes.
// ----------------------------------------------------------------------------
module testbench;
  import pcmvf_pkg::*;

  localparam int FADE_LEN      = FADE_LENGTH_DEF;
  // Settle time that covers several fading frames.
  localparam int SETTLE_CYCLES = 200;
  // Longest legal quiet spell is the long receiver hold plus a few frames;
  // the watchdog allows many times that.
  localparam int STALL_LIMIT   = 5000;
  localparam int LONG_HOLD     = 300;

  // One frame as it is offered on the input channel.
  typedef struct packed {
    logic [NUM_SLOTS-1:0][SMP_W-1:0] slot;
    logic [NUM_SLOTS-1:0]            mask;
    logic [SMP_W-1:0]                stream;
    logic                            stream_ok;
  } frame_t;

  // One mixed result as it leaves the output channel.
  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             silent;
  } mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  frame_t                    drv_frame = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SMP_W-1:0]   mixed_sample;
  logic                      silent;
  logic                      cfg_wr_en   = 1'b0;
  logic [GAIN_W-1:0]         cfg_wr_data = '0;

  // Frames waiting to be offered, and mixes waiting to come out.
  frame_t pending_frames[$];
  mix_t   expected_mix[$];

  // Local copy of the mixer state and its volume register.
  logic [GAIN_W-1:0] gain_model      = GAIN_RESET;
  logic              sounding_model  = 1'b0;
  int                fade_left_model = 0;

  // Bookkeeping shared between the processes. Each has a single writer.
  int req_sent      = 0;  // driver: requests put on the channel
  int req_taken     = 0;  // monitor: requests accepted by the block
  int results_seen  = 0;
  int silent_seen   = 0;
  int error_count   = 0;
  int idle_cycles   = 0;
  int gain_settings = 1;
  int hold_token    = 0;  // bumped by the sequence to ask for a long hold

  // Driver and receiver pacing state.
  int tx_gap_left   = 0;
  int tx_calm_left  = 0;
  int rx_stall_left = 0;
  int rx_calm_left  = 0;
  int rx_hold_left  = 0;
  int rx_hold_seen  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pcm_mixer_volume_fade_in u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .slot0_sample    (drv_frame.slot[0]),
    .slot1_sample    (drv_frame.slot[1]),
    .slot2_sample    (drv_frame.slot[2]),
    .slot3_sample    (drv_frame.slot[3]),
    .slot_valid_mask (drv_frame.mask),
    .stream_sample   (drv_frame.stream),
    .stream_valid    (drv_frame.stream_ok),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .mixed_sample    (mixed_sample),
    .silent          (silent),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Q16 gain: the arithmetic shift rounds toward minus infinity, which is
  // what the hardware does for negative products as well.
  function automatic longint apply_gain(logic [SMP_W-1:0] s);
    longint sv;
    longint g;
    sv = longint'($signed(s));
    g  = longint'(gain_model);
    return sat16((sv * g) >>> GAIN_SHIFT);
  endfunction

  // Mixes one frame and advances the fade state. The divisions truncate
  // toward zero, as SystemVerilog integer division does.
  function automatic mix_t mix_frame(frame_t f);
    longint sum;
    longint cnt;
    longint m;
    longint stp;
    mix_t   r;
    sum = 0;
    cnt = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (f.mask[i]) begin
        sum += apply_gain(f.slot[i]);
        cnt++;
      end
    end
    if (f.stream_ok) begin
      sum += apply_gain(f.stream);
      cnt++;
    end
    if (cnt == 0) begin
      // Silence clears the fade, so the next sounding frame starts a new one.
      sounding_model  = 1'b0;
      fade_left_model = 0;
      r.sample = '0;
      r.silent = 1'b1;
      return r;
    end
    m = sat16(sum / cnt);
    if (!sounding_model) begin
      sounding_model  = 1'b1;
      fade_left_model = FADE_LEN;
    end
    if (fade_left_model > 0) begin
      stp = FADE_LEN - fade_left_model + 1;
      m = (m * stp) / FADE_LEN;
      fade_left_model--;
    end
    r.sample = m[SMP_W-1:0];
    r.silent = 1'b0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(25, 80);
  endfunction

  // Samples lean on the rails so that saturation and rounding are hit often.
  function automatic logic [SMP_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return SMP_MAX;
    if (r == 1) return SMP_MIN;
    if (r == 2) return SMP_W'($urandom_range(0, 31)) - SMP_W'(16);
    return SMP_W'($urandom);
  endfunction

  // A sounding frame has at least one valid source. A silent frame carries
  // random sample values that the block must ignore.
  function automatic frame_t rand_frame(bit sounding);
    frame_t f;
    for (int i = 0; i < NUM_SLOTS; i++) f.slot[i] = rand_sample();
    f.stream    = rand_sample();
    f.mask      = NUM_SLOTS'($urandom);
    f.stream_ok = 1'($urandom);
    if (sounding && f.mask == '0 && !f.stream_ok) begin
      if ($urandom_range(0, 1) == 0) f.stream_ok = 1'b1;
      else f.mask[$urandom_range(0, NUM_SLOTS - 1)] = 1'b1;
    end
    if (!sounding) begin
      f.mask      = '0;
      f.stream_ok = 1'b0;
    end
    return f;
  endfunction

  function automatic frame_t make_frame(logic [SMP_W-1:0] a, logic [SMP_W-1:0] b,
                                        logic [SMP_W-1:0] c, logic [SMP_W-1:0] d,
                                        logic [NUM_SLOTS-1:0] m,
                                        logic [SMP_W-1:0] st, logic sv);
    frame_t f;
    f.slot[0]   = a;
    f.slot[1]   = b;
    f.slot[2]   = c;
    f.slot[3]   = d;
    f.mask      = m;
    f.stream    = st;
    f.stream_ok = sv;
    return f;
  endfunction

  // Queues n frames as runs of silence followed by runs of sound. Most sound
  // runs are shorter than a fade so that fades restart often; some outlast
  // it so the steady state after the fade is covered too.
  task automatic queue_random(int n);
    int k;
    int run;
    k = 0;
    while (k < n) begin
      run = $urandom_range(0, 2);
      if (run > n - k) run = n - k;
      repeat (run) begin
        pending_frames.push_back(rand_frame(1'b0));
        k++;
      end
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 34);
      if (run > n - k) run = n - k;
      repeat (run) begin
        pending_frames.push_back(rand_frame(1'b1));
        k++;
      end
    end
  endtask

  // Waits until every queued frame has been taken and every mix checked, then
  // gives the block time to settle.
  task automatic wait_idle();
    while (pending_frames.size() != 0 || in_valid || expected_mix.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The volume register is only written while the mixer is idle.
  task automatic set_gain(logic [GAIN_W-1:0] g);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= g;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    gain_model = g;
    gain_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued frames at the falling edge. A request that is up
  // stays up, unchanged, until the block accepts it; req_taken catching up
  // with req_sent tells the driver that the current request has gone.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : frame_driver
    logic   nv;
    frame_t nf;
    nv = in_valid;
    nf = drv_frame;
    if (in_valid && req_taken == req_sent) nv = 1'b0;
    if (!nv && !rst) begin
      if (tx_gap_left > 0) begin
        tx_gap_left--;
      end else if (pending_frames.size() > 0) begin
        nf = pending_frames.pop_front();
        nv = 1'b1;
        req_sent++;
        // Pick the gap that follows this request, with calm stretches.
        if (tx_calm_left > 0) begin
          tx_calm_left--;
          tx_gap_left = 0;
        end else if ($urandom_range(0, 19) == 0) begin
          tx_calm_left = $urandom_range(20, 40);
          tx_gap_left  = 0;
        end else begin
          tx_gap_left = idle_len();
        end
      end
    end
    in_valid  <= nv;
    drv_frame <= nf;
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure on the output channel, with calm
  // stretches, and a long hold when the sequence asks for one.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : result_sink
    logic nr;
    int   r;
    if (hold_token != rx_hold_seen) begin
      rx_hold_seen = hold_token;
      rx_hold_left = LONG_HOLD;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      nr = 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      nr = 1'b0;
    end else if (rx_calm_left > 0) begin
      rx_calm_left--;
      nr = 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        rx_calm_left = $urandom_range(30, 60);
        nr = 1'b1;
      end else if (r < 30) begin
        rx_stall_left = idle_len();
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
    end
    out_ready <= nr;
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge, predicts the mix of an accepted request and
  // checks an accepted result against the oldest prediction. It also runs
  // the watchdog, which ends the run if nothing moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : mix_monitor
    mix_t want;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_mix.push_back(mix_frame(drv_frame));
        req_taken++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (silent) silent_seen++;
        if (expected_mix.size() == 0) begin
          $display("%0t: result with no request pending: mixed_sample %0d silent %0b",
                   $time, mixed_sample, silent);
          error_count++;
        end else begin
          want = expected_mix.pop_front();
          if (mixed_sample !== want.sample) begin
            $display("%0t: mixed_sample mismatch: expected %0d actual %0d",
                     $time, $signed(want.sample), mixed_sample);
            error_count++;
          end
          if (silent !== want.silent) begin
            $display("%0t: silent mismatch: expected %0b actual %0b",
                     $time, want.silent, silent);
            error_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_mix.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed frames at unity gain, then random phases at a
  // range of gains. Each gain change waits for the mixer to drain, so the
  // sender also pauses until every outstanding result has come back.
  // --------------------------------------------------------------------------
  initial begin : sequence_main
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames. Silence first, including silence with junk samples,
    // then a fade that starts on rail-to-rail frames and single sources.
    pending_frames.push_back(make_frame('0, '0, '0, '0, 4'b0000, '0, 1'b0));
    pending_frames.push_back(make_frame(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, 4'b0000,
                                        SMP_MAX, 1'b0));
    pending_frames.push_back(make_frame(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, 4'b1111,
                                        SMP_MAX, 1'b1));
    pending_frames.push_back(make_frame(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN, 4'b1111,
                                        SMP_MIN, 1'b1));
    pending_frames.push_back(make_frame(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, 4'b1111,
                                        SMP_MIN, 1'b1));
    pending_frames.push_back(make_frame(16'hFFFF, '0, '0, '0, 4'b0001, '0, 1'b0));
    pending_frames.push_back(make_frame('0, 16'h0001, '0, '0, 4'b0010, '0, 1'b0));
    pending_frames.push_back(make_frame('0, '0, SMP_MIN, '0, 4'b0100, '0, 1'b0));
    pending_frames.push_back(make_frame('0, '0, '0, SMP_MAX, 4'b1000, '0, 1'b0));
    pending_frames.push_back(make_frame(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, 4'b0000,
                                        SMP_MIN, 1'b1));
    pending_frames.push_back(make_frame(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 4'b1010,
                                        16'h1234, 1'b1));
    pending_frames.push_back(make_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1111,
                                        16'hFFFF, 1'b1));
    pending_frames.push_back(make_frame(16'h0001, 16'h0002, 16'hFFFD, '0, 4'b0111,
                                        '0, 1'b0));
    // Silence in the middle of a fade, then a fresh fade.
    pending_frames.push_back(make_frame(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, 4'b0000,
                                        SMP_MAX, 1'b0));
    pending_frames.push_back(make_frame(SMP_MAX, '0, '0, '0, 4'b0001, '0, 1'b0));
    pending_frames.push_back(make_frame(SMP_MIN, '0, '0, '0, 4'b0001, '0, 1'b0));
    pending_frames.push_back(make_frame(16'hFFE1, 16'h001F, '0, '0, 4'b0011, '0, 1'b0));
    pending_frames.push_back(make_frame('0, '0, '0, '0, 4'b0000, '0, 1'b0));
    pending_frames.push_back(make_frame('0, '0, '0, '0, 4'b0000, 16'hFFFF, 1'b1));
    pending_frames.push_back(make_frame(16'h7FFE, 16'h8001, '0, '0, 4'b0011, '0, 1'b0));

    // Random frames at unity gain, opening with a long receiver hold while
    // the sender keeps offering, so the mixer fills and stalls its input.
    wait_idle();
    hold_token = hold_token + 1;
    queue_random(120);

    // Gain extremes: mute, then the largest value the register holds.
    set_gain('0);
    queue_random(60);
    set_gain({GAIN_W{1'b1}});
    queue_random(100);

    // Half gain and two arbitrary gains.
    set_gain(GAIN_W'(32768));
    queue_random(80);
    set_gain(GAIN_W'($urandom_range(1, 131070)));
    queue_random(80);
    set_gain(GAIN_W'($urandom_range(1, 131070)));
    queue_random(80);

    // Back to unity.
    set_gain(GAIN_RESET);
    queue_random(40);

    wait_idle();
    $display("Summary: %0d frames mixed over %0d gain settings, %0d results checked (%0d silent)",
             req_taken, gain_settings, results_seen, silent_seen);
    if (error_count == 0 && expected_mix.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, expected_mix.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
